[rtl/core/gsrp_pkg.sv]
`default_nettype none

package gsrp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int RULE_CHARS  = 8;
    localparam int RULE_SLOTS  = 5;
    localparam int BODY_REGS   = 5;
    localparam int MAX_RESULTS = 18;

    localparam int SYM_W       = 8;
    localparam int ACTION_W    = 2;
    localparam int RULE_W      = 3;
    localparam int OUT_DEPTH_W = 5;
    localparam int CFG_W       = 64;
    localparam int RULE_CNT_W  = 3;

    localparam logic [SYM_W-1:0] SYM_E = 8'h45;

    localparam int CHARS_MAX  = (RULE_CHARS < 8) ? RULE_CHARS : 8;
    localparam int ACTIVE_MAX = (RULE_SLOTS < BODY_REGS) ? RULE_SLOTS : BODY_REGS;
    localparam int DEPTH_W    = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W      = $clog2(STACK_DEPTH);
    localparam int LEN_W      = $clog2(CHARS_MAX + 1);
    localparam int CHAR_IDX_W = (CHARS_MAX > 1) ? $clog2(CHARS_MAX) : 1;
    localparam int SUM_W      = ((DEPTH_W > LEN_W) ? DEPTH_W : LEN_W) + 1;
    localparam int CNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int ADDR_W     = $clog2(8 * (BODY_REGS + 1));
    localparam int REG_IDX_W  = ADDR_W - 3;

    localparam logic [REG_IDX_W-1:0] REG_BODY_A     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BODY_B     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BODY_C     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BODY_D     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BODY_E     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RULE_COUNT = 3'd5;

    localparam logic [ACTION_W-1:0] ACT_SHIFT  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REDUCE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ACCEPT = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_REJECT = 2'd3;

    typedef struct packed {
        logic [CHARS_MAX-1:0][SYM_W-1:0] chars;
        logic [LEN_W-1:0]                len;
        logic                            usable;
    } rule_cfg_t;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic [RULE_W-1:0]      rule_used;
        logic [OUT_DEPTH_W-1:0] depth_after;
        logic                   overflowed;
        logic                   end_of_run;
    } result_t;

    // The body ends at the first zero byte or after CHARS_MAX bytes.
    function automatic logic [LEN_W-1:0] body_len(input logic [CFG_W-1:0] body);
        logic [LEN_W-1:0] n;
        logic             run;
        n   = '0;
        run = 1'b1;
        for (int k = 0; k < CHARS_MAX; k++)
        begin
            if (run && body[8*k +: 8] != 8'h00)
            begin
                n = n + LEN_W'(1);
            end
            else
            begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[rtl/core/gsrp_sym_if.sv]
`default_nettype none

interface gsrp_sym_if;
    logic                        valid;
    logic                        ready;
    logic [gsrp_pkg::SYM_W-1:0]  symbol;
    logic                        last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

`default_nettype wire

[rtl/core/gsrp_act_if.sv]
`default_nettype none

interface gsrp_act_if;
    logic                              valid;
    logic                              ready;
    logic [gsrp_pkg::ACTION_W-1:0]     action;
    logic [gsrp_pkg::RULE_W-1:0]       rule_used;
    logic [gsrp_pkg::OUT_DEPTH_W-1:0]  depth_after;
    logic                              overflowed;
    logic                              end_of_run;

    modport source (output valid, output action, output rule_used, output depth_after,
                    output overflowed, output end_of_run, input ready);
    modport sink (input valid, input action, input rule_used, input depth_after,
                  input overflowed, input end_of_run, output ready);
endinterface

`default_nettype wire

[rtl/core/gsrp_cfg_regs.sv]
`default_nettype none

module gsrp_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [gsrp_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [gsrp_pkg::CFG_W-1:0]      pwdata,
    output logic      [gsrp_pkg::CFG_W-1:0]      prdata,
    output logic                                 pready,
    output gsrp_pkg::rule_cfg_t                  rules [gsrp_pkg::BODY_REGS],
    output logic      [gsrp_pkg::RULE_W-1:0]     active_rules
);

    logic [gsrp_pkg::CFG_W-1:0]      body_reg [gsrp_pkg::BODY_REGS];
    logic [gsrp_pkg::RULE_CNT_W-1:0] rule_count_reg;
    logic [gsrp_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                            wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[gsrp_pkg::ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < gsrp_pkg::BODY_REGS; k++)
            begin
                body_reg[k] <= '0;
            end
            rule_count_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                gsrp_pkg::REG_BODY_A:     body_reg[0] <= pwdata;
                gsrp_pkg::REG_BODY_B:     body_reg[1] <= pwdata;
                gsrp_pkg::REG_BODY_C:     body_reg[2] <= pwdata;
                gsrp_pkg::REG_BODY_D:     body_reg[3] <= pwdata;
                gsrp_pkg::REG_BODY_E:     body_reg[4] <= pwdata;
                gsrp_pkg::REG_RULE_COUNT: rule_count_reg <= pwdata[gsrp_pkg::RULE_CNT_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            gsrp_pkg::REG_BODY_A:     prdata = body_reg[0];
            gsrp_pkg::REG_BODY_B:     prdata = body_reg[1];
            gsrp_pkg::REG_BODY_C:     prdata = body_reg[2];
            gsrp_pkg::REG_BODY_D:     prdata = body_reg[3];
            gsrp_pkg::REG_BODY_E:     prdata = body_reg[4];
            gsrp_pkg::REG_RULE_COUNT: prdata = gsrp_pkg::CFG_W'(rule_count_reg);
            default:                  prdata = '0;
        endcase
    end

    // A rule whose body is empty or is the single symbol E never applies.
    always_comb
    begin
        for (int k = 0; k < gsrp_pkg::BODY_REGS; k++)
        begin
            rules[k].chars  = body_reg[k][gsrp_pkg::CHARS_MAX*gsrp_pkg::SYM_W-1:0];
            rules[k].len    = gsrp_pkg::body_len(body_reg[k]);
            rules[k].usable = (rules[k].len != '0) &&
                              !(rules[k].len == gsrp_pkg::LEN_W'(1) &&
                                body_reg[k][gsrp_pkg::SYM_W-1:0] == gsrp_pkg::SYM_E);
        end
    end

    assign active_rules = (rule_count_reg > gsrp_pkg::ACTIVE_MAX) ?
                          gsrp_pkg::RULE_W'(gsrp_pkg::ACTIVE_MAX) :
                          gsrp_pkg::RULE_W'(rule_count_reg);

endmodule

`default_nettype wire

[rtl/core/greedy_shift_reduce_parser_core.sv]
// Greedy shift-reduce recognizer. Each symbols transaction is shifted onto a
// sixteen-entry stack (a full stack sets the overflow flag instead) and
// reported as a shift; the core then searches for the shortest stack suffix
// that equals a rule body (lowest rule index on a tie), replaces it with E,
// reports the reduction and searches again, and on the last symbol of a
// string reports accept or reject and clears the stack. One 8-bit
// comparator does all matching, one stack character per cycle: a search
// pass tries the active rules in index order, skips a rule that cannot
// match, compares a candidate character by character up to the first
// mismatch, and closes once every rule is tried. An item is shifted, then
// searched once per reduction (at most 16) and once more; its results are
// emitted in order, and an emit waits while the output is stalled. The core
// takes no new symbol until the last result of the current one is in the
// output register. Rule registers are written over the APB port at byte
// address 8 * index; the user must write them only while idle, which the
// core itself does not enforce.

`default_nettype none

module greedy_shift_reduce_parser_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    gsrp_sym_if.sink                           symbols,
    gsrp_act_if.source                         actions,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gsrp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [gsrp_pkg::CFG_W-1:0]    pwdata,
    output logic      [gsrp_pkg::CFG_W-1:0]    prdata,
    output logic                               pready
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SEARCH  = 3'd1;
    localparam logic [2:0] ST_REDUCE  = 3'd2;
    localparam logic [2:0] ST_FINISH  = 3'd3;
    localparam logic [2:0] ST_VERDICT = 3'd4;

    localparam int DW = gsrp_pkg::DEPTH_W;
    localparam int SW = gsrp_pkg::SUM_W;

    gsrp_pkg::rule_cfg_t                  rules [gsrp_pkg::BODY_REGS];
    logic [gsrp_pkg::RULE_W-1:0]          active_rules;

    logic [2:0]                           state_reg, state_next;
    logic [DW-1:0]                        depth_reg, depth_next;
    logic                                 ovf_reg, ovf_next;
    logic                                 last_reg, last_next;
    logic [gsrp_pkg::CNT_W-1:0]           k_reg, k_next;
    logic [gsrp_pkg::RULE_W-1:0]          r_reg, r_next;
    logic [gsrp_pkg::CHAR_IDX_W-1:0]      i_reg, i_next;
    logic                                 best_valid_reg, best_valid_next;
    logic [gsrp_pkg::RULE_W-1:0]          best_rule_reg, best_rule_next;
    logic [gsrp_pkg::LEN_W-1:0]           best_len_reg, best_len_next;
    gsrp_pkg::result_t                    pend_reg, pend_next;
    gsrp_pkg::result_t                    out_reg, out_next;
    logic                                 out_valid_reg, out_valid_next;

    logic [gsrp_pkg::SYM_W-1:0]           stack_reg [gsrp_pkg::STACK_DEPTH];
    logic                                 stack_we;
    logic [gsrp_pkg::IDX_W-1:0]           stack_wa;
    logic [gsrp_pkg::SYM_W-1:0]           stack_wd;

    gsrp_pkg::rule_cfg_t                  cur;
    logic                                 search_done;
    logic                                 eligible;
    logic [SW-1:0]                        rd_sum;
    logic                                 char_eq;
    logic                                 last_char;
    logic                                 out_free;
    logic                                 in_acc;
    logic                                 accepted;
    logic [DW-1:0]                        red_depth;
    logic [SW-1:0]                        red_base;

    gsrp_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .rules        (rules),
        .active_rules (active_rules)
    );

    assign symbols.ready       = (state_reg == ST_IDLE);
    assign in_acc              = symbols.valid && symbols.ready;
    assign out_free            = !out_valid_reg || actions.ready;

    assign actions.valid       = out_valid_reg;
    assign actions.action      = out_reg.action;
    assign actions.rule_used   = out_reg.rule_used;
    assign actions.depth_after = out_reg.depth_after;
    assign actions.overflowed  = out_reg.overflowed;
    assign actions.end_of_run  = out_reg.end_of_run;

    // Shared character comparator.
    assign cur         = rules[r_reg];
    assign search_done = (r_reg >= active_rules) || (k_reg >= gsrp_pkg::MAX_RESULTS - 1);
    assign eligible    = cur.usable && (SW'(cur.len) <= SW'(depth_reg)) &&
                         (!best_valid_reg || cur.len < best_len_reg);
    assign rd_sum      = SW'(depth_reg) - SW'(cur.len) + SW'(i_reg);
    assign char_eq     = stack_reg[rd_sum[gsrp_pkg::IDX_W-1:0]] == cur.chars[i_reg];
    assign last_char   = (gsrp_pkg::LEN_W'(i_reg) + gsrp_pkg::LEN_W'(1)) == cur.len;

    assign red_base    = SW'(depth_reg) - SW'(best_len_reg);
    assign red_depth   = DW'(red_base + SW'(1));
    assign accepted    = !ovf_reg && (depth_reg == DW'(1)) && (stack_reg[0] == gsrp_pkg::SYM_E);

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        ovf_next        = ovf_reg;
        last_next       = last_reg;
        k_next          = k_reg;
        r_next          = r_reg;
        i_next          = i_reg;
        best_valid_next = best_valid_reg;
        best_rule_next  = best_rule_reg;
        best_len_next   = best_len_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !actions.ready;
        stack_we        = 1'b0;
        stack_wa        = depth_reg[gsrp_pkg::IDX_W-1:0];
        stack_wd        = symbols.symbol;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (depth_reg < gsrp_pkg::STACK_DEPTH)
                    begin
                        stack_we   = 1'b1;
                        depth_next = depth_reg + DW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    pend_next.action      = gsrp_pkg::ACT_SHIFT;
                    pend_next.rule_used   = '0;
                    pend_next.depth_after = gsrp_pkg::OUT_DEPTH_W'(depth_next);
                    pend_next.overflowed  = ovf_next;
                    pend_next.end_of_run  = 1'b0;
                    last_next             = symbols.last_symbol;
                    k_next                = gsrp_pkg::CNT_W'(1);
                    r_next                = '0;
                    i_next                = '0;
                    best_valid_next       = 1'b0;
                    state_next            = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (search_done)
                begin
                    state_next = best_valid_reg ? ST_REDUCE : ST_FINISH;
                end
                else if (!eligible || !char_eq)
                begin
                    r_next = r_reg + gsrp_pkg::RULE_W'(1);
                    i_next = '0;
                end
                else if (last_char)
                begin
                    best_valid_next = 1'b1;
                    best_rule_next  = r_reg;
                    best_len_next   = cur.len;
                    r_next          = r_reg + gsrp_pkg::RULE_W'(1);
                    i_next          = '0;
                end
                else
                begin
                    i_next = i_reg + gsrp_pkg::CHAR_IDX_W'(1);
                end
            end
            ST_REDUCE:
            begin
                if (out_free)
                begin
                    out_next              = pend_reg;
                    out_valid_next        = 1'b1;
                    stack_we              = 1'b1;
                    stack_wa              = red_base[gsrp_pkg::IDX_W-1:0];
                    stack_wd              = gsrp_pkg::SYM_E;
                    depth_next            = red_depth;
                    pend_next.action      = gsrp_pkg::ACT_REDUCE;
                    pend_next.rule_used   = best_rule_reg;
                    pend_next.depth_after = gsrp_pkg::OUT_DEPTH_W'(red_depth);
                    pend_next.overflowed  = ovf_reg;
                    pend_next.end_of_run  = 1'b0;
                    k_next                = k_reg + gsrp_pkg::CNT_W'(1);
                    r_next                = '0;
                    i_next                = '0;
                    best_valid_next       = 1'b0;
                    state_next            = ST_SEARCH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_next            = pend_reg;
                    out_next.end_of_run = !last_reg;
                    out_valid_next      = 1'b1;
                    state_next          = last_reg ? ST_VERDICT : ST_IDLE;
                end
            end
            ST_VERDICT:
            begin
                if (out_free)
                begin
                    out_next.action      = accepted ? gsrp_pkg::ACT_ACCEPT : gsrp_pkg::ACT_REJECT;
                    out_next.rule_used   = '0;
                    out_next.depth_after = gsrp_pkg::OUT_DEPTH_W'(depth_reg);
                    out_next.overflowed  = ovf_reg;
                    out_next.end_of_run  = 1'b1;
                    out_valid_next       = 1'b1;
                    depth_next           = '0;
                    ovf_next             = 1'b0;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            depth_reg      <= '0;
            ovf_reg        <= 1'b0;
            last_reg       <= 1'b0;
            k_reg          <= '0;
            r_reg          <= '0;
            i_reg          <= '0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            depth_reg      <= depth_next;
            ovf_reg        <= ovf_next;
            last_reg       <= last_next;
            k_reg          <= k_next;
            r_reg          <= r_next;
            i_reg          <= i_next;
            best_valid_reg <= best_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_rule_reg <= best_rule_next;
        best_len_reg  <= best_len_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        if (stack_we)
        begin
            stack_reg[stack_wa] <= stack_wd;
        end
    end

endmodule

`default_nettype wire

[rtl/core/gsrp_checker.sv]
`default_nettype none

module gsrp_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic [gsrp_pkg::ACTION_W-1:0]       action,
    input  wire logic [gsrp_pkg::RULE_W-1:0]         rule_used,
    input  wire logic [gsrp_pkg::OUT_DEPTH_W-1:0]    depth_after,
    input  wire logic                                overflowed,
    input  wire logic                                end_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result transaction dropped before it was taken.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input taken again before the current symbol finished.");

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> depth_after <= gsrp_pkg::STACK_DEPTH)
        else $error("Reported stack depth exceeds the stack size.");

    a_accept_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == gsrp_pkg::ACT_ACCEPT |->
            depth_after == gsrp_pkg::OUT_DEPTH_W'(1) && !overflowed && end_of_run)
        else $error("Accept reported for a stack that is not a single E.");

    a_rule_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != gsrp_pkg::ACT_REDUCE |-> rule_used == '0)
        else $error("Rule index reported on a result that is not a reduction.");

endmodule

bind greedy_shift_reduce_parser_core gsrp_checker u_gsrp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (symbols.valid),
    .in_ready    (symbols.ready),
    .out_valid   (actions.valid),
    .out_ready   (actions.ready),
    .action      (actions.action),
    .rule_used   (actions.rule_used),
    .depth_after (actions.depth_after),
    .overflowed  (actions.overflowed),
    .end_of_run  (actions.end_of_run)
);

`default_nettype wire
